// File: rtl/assert_macros.svh
// Assertion macros used by the fader top level.
// Needs nothing else; the files that check their own logic take it in.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at each clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// File: rtl/bshf_pkg.sv
// Types, codes and constants of the bicolour sweep/hold fader.
// No dependencies; used by the interfaces, controller, datapath and top level.
package bshf_pkg;

   // field widths
   localparam int NOW_W     = 32;
   localparam int COLOR_W   = 24;
   localparam int CHAN_W    = 8;
   localparam int HOLD_W    = 32;
   localparam int ELAPSED_W = 32;
   localparam int PROD_W    = ELAPSED_W + CHAN_W;
   localparam int PHASE_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   localparam logic [CHAN_W-1:0] CH_MAX = 8'd255;

   typedef logic [PHASE_W-1:0] phase_type;

   localparam phase_type PH_START      = 3'd0;
   localparam phase_type PH_SWEEP_UP   = 3'd1;
   localparam phase_type PH_HOLD_UP    = 3'd2;
   localparam phase_type PH_SWEEP_DOWN = 3'd3;
   localparam phase_type PH_HOLD_DOWN  = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_UP_COLOR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DOWN_COLOR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_TIME  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_TIME = 3'd3;

   // channel select: red, green, blue in turn
   typedef logic [1:0] chan_sel_type;
   localparam chan_sel_type CH_RED   = 2'd0;
   localparam chan_sel_type CH_GREEN = 2'd1;
   localparam chan_sel_type CH_BLUE  = 2'd2;

   // one quotient bit per divider step
   typedef logic [2:0] div_cnt_type;
   localparam div_cnt_type DIV_LAST = 3'd7;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EVAL   = 6'b000010,
      ST_MUL    = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_STORE  = 6'b010000,
      ST_FINISH = 6'b100000
   } ctl_state_type;

   typedef struct packed {
      logic         capture;
      logic         eval;
      logic         mul;
      logic         div_step;
      logic         store;
      logic         load_out;
      chan_sel_type ch;
   } cmd_type;

   typedef struct packed {
      logic blend;
      logic out_free;
   } stat_type;

   // pick one 8-bit channel out of a packed RGB word
   function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] rgb,
                                                 input chan_sel_type ch);
      logic [CHAN_W-1:0] c;
      case (ch)
         CH_RED:   c = rgb[23:16];
         CH_GREEN: c = rgb[15:8];
         CH_BLUE:  c = rgb[7:0];
         default:  c = '0;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/bshf_ifs.sv
// Valid/ready channel interfaces: tick transactions in, colour transactions out.
// Depends on bshf_pkg.
interface bshf_req_if;
   logic                       valid;
   logic                       ready;
   logic [bshf_pkg::NOW_W-1:0] now;

   modport source (output valid, output now, input ready);
   modport sink   (input valid, input now, output ready);
endinterface

interface bshf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bshf_pkg::CHAN_W-1:0] red;
   logic [bshf_pkg::CHAN_W-1:0] green;
   logic [bshf_pkg::CHAN_W-1:0] blue;
   logic                        changed;
   bshf_pkg::phase_type         phase;

   modport source (output valid, output red, output green, output blue,
                   output changed, output phase, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input changed, input phase, output ready);
endinterface

// File: rtl/bicolor_sweep_hold_fader_unit.sv
// Bicolour sweep/hold fader. One tick transaction in, one colour transaction out.
// A tick that blends (start, sweep, end of hold) passes capture, evaluate, then per channel a
// multiply, eight divide steps and a store, then finish; a tick on which the colour is held
// or a sweep ends goes from evaluate straight to finish, which waits for a free output register.
// One tick is in flight at a time; the one-bit-per-cycle divider is shared by red, green, blue.
// Synchronous active-high reset: start phase, colours and hold 0, sweep 1, empty output.
`include "assert_macros.svh"

module bicolor_sweep_hold_fader_unit #(
   parameter int TIME_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   bshf_req_if.sink                       req_chan,
   bshf_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [bshf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bshf_pkg::CSR_DAT_W-1:0] csr_wdata
);

   bshf_pkg::cmd_type  cmd;
   bshf_pkg::stat_type st;
   logic               req_fire;
   logic               rsp_in_hold;
   logic               rsp_phase_bad;

   bshf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   bshf_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_now     (req_chan.now),
      .cmd         (cmd),
      .st          (st),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_red     (rsp_chan.red),
      .rsp_green   (rsp_chan.green),
      .rsp_blue    (rsp_chan.blue),
      .rsp_changed (rsp_chan.changed),
      .rsp_phase   (rsp_chan.phase)
   );

   assign req_fire      = req_chan.valid && req_chan.ready;
   assign rsp_in_hold   = (rsp_chan.phase == bshf_pkg::PH_HOLD_UP)
                       || (rsp_chan.phase == bshf_pkg::PH_HOLD_DOWN);
   assign rsp_phase_bad = (rsp_chan.phase == bshf_pkg::PH_START)
                       || (rsp_chan.phase > bshf_pkg::PH_HOLD_DOWN);

   // one transaction in flight at a time
   `ASSERT_PROP(a_one_in_flight, clock, reset, req_fire |=> !req_chan.ready)
   // the output register is only loaded when it is free
   `ASSERT_NEVER(a_load_when_busy, clock, reset, cmd.load_out && !st.out_free)
   // an unchanged colour only comes out of a hold phase
   `ASSERT_PROP(a_keep_in_hold, clock, reset, (rsp_chan.valid && !rsp_chan.changed) |-> rsp_in_hold)
   // reported phase is never start or an unused code
   `ASSERT_NEVER(a_phase_legal, clock, reset, rsp_chan.valid && rsp_phase_bad)

endmodule

// File: rtl/bshf_ctrl.sv
// Sequencer of the fader: walks evaluate, multiply, divide and store per channel.
// Depends on bshf_pkg; drives the datapath through the command struct.
module bshf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bshf_pkg::stat_type st,
   output bshf_pkg::cmd_type  cmd
);

   bshf_pkg::ctl_state_type state_ff, state_in;
   bshf_pkg::chan_sel_type  ch_ff, ch_in;
   bshf_pkg::div_cnt_type   cnt_ff, cnt_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.ch       = ch_ff;
      req_ready    = 1'b0;
      case (state_ff)
         bshf_pkg::ST_IDLE: begin
            // no transaction is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = bshf_pkg::ST_EVAL;
            end
         end
         bshf_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            ch_in    = bshf_pkg::CH_RED;
            state_in = st.blend ? bshf_pkg::ST_MUL : bshf_pkg::ST_FINISH;
         end
         bshf_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = bshf_pkg::ST_DIV;
         end
         bshf_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == bshf_pkg::DIV_LAST) begin
               state_in = bshf_pkg::ST_STORE;
            end
         end
         bshf_pkg::ST_STORE: begin
            cmd.store = 1'b1;
            if (ch_ff == bshf_pkg::CH_BLUE) begin
               state_in = bshf_pkg::ST_FINISH;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = bshf_pkg::ST_MUL;
            end
         end
         bshf_pkg::ST_FINISH: begin
            // wait for the output register to free up
            if (st.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = bshf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bshf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bshf_pkg::ST_IDLE;
         ch_ff    <= bshf_pkg::CH_RED;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: rtl/bshf_dp.sv
// Datapath of the fader: config registers, phase state, 32x8 multiplier,
// restoring divider (one quotient bit per cycle) and output register. Depends on bshf_pkg.
module bshf_dp #(
   parameter int TIME_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bshf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bshf_pkg::CSR_DAT_W-1:0]    csr_wdata,
   input  logic [bshf_pkg::NOW_W-1:0]        req_now,
   input  bshf_pkg::cmd_type                 cmd,
   output bshf_pkg::stat_type                st,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [bshf_pkg::CHAN_W-1:0]       rsp_red,
   output logic [bshf_pkg::CHAN_W-1:0]       rsp_green,
   output logic [bshf_pkg::CHAN_W-1:0]       rsp_blue,
   output logic                              rsp_changed,
   output bshf_pkg::phase_type               rsp_phase
);

   localparam int WIDE_W = (TIME_BITS > bshf_pkg::HOLD_W) ? TIME_BITS : bshf_pkg::HOLD_W;

   // configuration
   logic [bshf_pkg::COLOR_W-1:0] up_color_ff, up_color_in;
   logic [bshf_pkg::COLOR_W-1:0] down_color_ff, down_color_in;
   logic [bshf_pkg::HOLD_W-1:0]  hold_time_ff, hold_time_in;
   logic [bshf_pkg::HOLD_W-1:0]  sweep_time_ff, sweep_time_in;

   // sequencing state
   bshf_pkg::phase_type          phase_ff, phase_in;
   logic [TIME_BITS-1:0]         sweep_start_ff, sweep_start_in;
   logic [TIME_BITS-1:0]         hold_start_ff, hold_start_in;
   logic [bshf_pkg::COLOR_W-1:0] last_color_ff, last_color_in;

   // per-transaction working registers
   logic [TIME_BITS-1:0]           now_ff, now_in;
   logic [bshf_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                           up_ff, up_in;
   logic                           changed_ff, changed_in;
   logic [bshf_pkg::COLOR_W-1:0]   color_ff, color_in;
   logic [bshf_pkg::ELAPSED_W-1:0] rem_ff, rem_in;
   logic [bshf_pkg::CHAN_W-1:0]    low_ff, low_in;
   logic [bshf_pkg::CHAN_W-1:0]    quo_ff, quo_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bshf_pkg::CHAN_W-1:0] rsp_red_ff, rsp_red_in;
   logic [bshf_pkg::CHAN_W-1:0] rsp_green_ff, rsp_green_in;
   logic [bshf_pkg::CHAN_W-1:0] rsp_blue_ff, rsp_blue_in;
   logic                        rsp_changed_ff, rsp_changed_in;
   bshf_pkg::phase_type         rsp_phase_ff, rsp_phase_in;

   // evaluation terms
   logic [WIDE_W-1:0]              now_wide;
   logic [TIME_BITS-1:0]           el_sweep, el_hold;
   logic [WIDE_W-1:0]              el_sweep_wide;
   logic                           hold_over, sweep_over;
   bshf_pkg::phase_type            ev_phase;
   logic                           ev_blend, ev_keep, ev_up, ev_mark_sweep, ev_mark_hold;
   logic [bshf_pkg::ELAPSED_W-1:0] ev_elapsed;
   logic [bshf_pkg::COLOR_W-1:0]   ev_color;

   // channel terms
   logic [bshf_pkg::COLOR_W-1:0]   from_color, to_color;
   logic [bshf_pkg::CHAN_W-1:0]    chan_a, chan_b, mag;
   logic                           neg;
   logic [bshf_pkg::PROD_W-1:0]    prod;
   logic [bshf_pkg::ELAPSED_W:0]   trial, diff;
   logic                           ge;
   logic [bshf_pkg::CHAN_W-1:0]    q_eff;
   logic signed [9:0]              a_s, q_s, sum_s;
   logic [bshf_pkg::CHAN_W-1:0]    sat;

   assign now_wide      = WIDE_W'(req_now);
   assign el_sweep      = now_ff - sweep_start_ff;
   assign el_hold       = now_ff - hold_start_ff;
   assign el_sweep_wide = WIDE_W'(el_sweep);
   assign hold_over     = WIDE_W'(el_hold) > WIDE_W'(hold_time_ff);
   assign sweep_over    = el_sweep_wide > WIDE_W'(sweep_time_ff);

   // phase decision for the captured tick
   always_comb begin
      ev_phase      = phase_ff;
      ev_blend      = 1'b0;
      ev_keep       = 1'b0;
      ev_up         = 1'b1;
      ev_mark_sweep = 1'b0;
      ev_mark_hold  = 1'b0;
      ev_elapsed    = '0;
      ev_color      = last_color_ff;
      case (phase_ff)
         bshf_pkg::PH_HOLD_UP, bshf_pkg::PH_HOLD_DOWN: begin
            if (hold_over) begin
               // next sweep starts now, elapsed zero
               ev_up         = (phase_ff == bshf_pkg::PH_HOLD_DOWN);
               ev_phase      = ev_up ? bshf_pkg::PH_SWEEP_UP : bshf_pkg::PH_SWEEP_DOWN;
               ev_mark_sweep = 1'b1;
               ev_blend      = 1'b1;
            end else begin
               ev_keep = 1'b1;
            end
         end
         bshf_pkg::PH_SWEEP_UP, bshf_pkg::PH_SWEEP_DOWN: begin
            ev_up = (phase_ff == bshf_pkg::PH_SWEEP_UP);
            if (sweep_over) begin
               ev_phase     = ev_up ? bshf_pkg::PH_HOLD_UP : bshf_pkg::PH_HOLD_DOWN;
               ev_mark_hold = 1'b1;
               ev_color     = ev_up ? up_color_ff : down_color_ff;
            end else begin
               ev_blend   = 1'b1;
               ev_elapsed = el_sweep_wide[bshf_pkg::ELAPSED_W-1:0];
            end
         end
         default: begin
            // start phase and unused codes
            ev_phase      = bshf_pkg::PH_SWEEP_UP;
            ev_mark_sweep = 1'b1;
            ev_blend      = 1'b1;
         end
      endcase
   end

   // channel operands: sweep up fades from down colour to up colour
   always_comb begin
      from_color = up_ff ? down_color_ff : up_color_ff;
      to_color   = up_ff ? up_color_ff : down_color_ff;
      chan_a     = bshf_pkg::chan_of(from_color, cmd.ch);
      chan_b     = bshf_pkg::chan_of(to_color, cmd.ch);
      neg        = chan_b < chan_a;
      mag        = neg ? (chan_a - chan_b) : (chan_b - chan_a);
      prod       = {{bshf_pkg::CHAN_W{1'b0}}, elapsed_ff}
                 * {{bshf_pkg::ELAPSED_W{1'b0}}, mag};
   end

   // one restoring divide step; remainder stays below sweep_time
   always_comb begin
      trial = {rem_ff, low_ff[bshf_pkg::CHAN_W-1]};
      diff  = trial - {1'b0, sweep_time_ff};
      ge    = trial >= {1'b0, sweep_time_ff};
   end

   // channel sum with saturation; zero sweep time gives no sweep term
   always_comb begin
      q_eff = (sweep_time_ff == '0) ? '0 : quo_ff;
      a_s   = $signed({2'b00, chan_a});
      q_s   = $signed({2'b00, q_eff});
      sum_s = neg ? (a_s - q_s) : (a_s + q_s);
      if (sum_s < 10'sd0) begin
         sat = '0;
      end else if (sum_s > $signed({2'b00, bshf_pkg::CH_MAX})) begin
         sat = bshf_pkg::CH_MAX;
      end else begin
         sat = sum_s[bshf_pkg::CHAN_W-1:0];
      end
   end

   // next-value logic
   always_comb begin
      up_color_in    = up_color_ff;
      down_color_in  = down_color_ff;
      hold_time_in   = hold_time_ff;
      sweep_time_in  = sweep_time_ff;
      phase_in       = phase_ff;
      sweep_start_in = sweep_start_ff;
      hold_start_in  = hold_start_ff;
      last_color_in  = last_color_ff;
      now_in         = now_ff;
      elapsed_in     = elapsed_ff;
      up_in          = up_ff;
      changed_in     = changed_ff;
      color_in       = color_ff;
      rem_in         = rem_ff;
      low_in         = low_ff;
      quo_in         = quo_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_red_in     = rsp_red_ff;
      rsp_green_in   = rsp_green_ff;
      rsp_blue_in    = rsp_blue_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_phase_in   = rsp_phase_ff;

      // register writes restart the cycle; unknown indexes are ignored
      if (csr_we) begin
         case (csr_index)
            bshf_pkg::REG_UP_COLOR: begin
               up_color_in = csr_wdata[bshf_pkg::COLOR_W-1:0];
               phase_in    = bshf_pkg::PH_START;
            end
            bshf_pkg::REG_DOWN_COLOR: begin
               down_color_in = csr_wdata[bshf_pkg::COLOR_W-1:0];
               phase_in      = bshf_pkg::PH_START;
            end
            bshf_pkg::REG_HOLD_TIME: begin
               hold_time_in = csr_wdata[bshf_pkg::HOLD_W-1:0];
               phase_in     = bshf_pkg::PH_START;
            end
            bshf_pkg::REG_SWEEP_TIME: begin
               sweep_time_in = csr_wdata[bshf_pkg::HOLD_W-1:0];
               phase_in      = bshf_pkg::PH_START;
            end
            default: begin
            end
         endcase
      end

      if (cmd.capture) begin
         now_in = now_wide[TIME_BITS-1:0];
      end

      if (cmd.eval) begin
         phase_in   = ev_phase;
         elapsed_in = ev_elapsed;
         up_in      = ev_up;
         changed_in = !ev_keep;
         color_in   = ev_color;
         if (ev_mark_sweep) begin
            sweep_start_in = now_ff;
         end
         if (ev_mark_hold) begin
            hold_start_in = now_ff;
         end
      end

      if (cmd.mul) begin
         rem_in = prod[bshf_pkg::PROD_W-1:bshf_pkg::CHAN_W];
         low_in = prod[bshf_pkg::CHAN_W-1:0];
         quo_in = '0;
      end

      if (cmd.div_step) begin
         rem_in = ge ? diff[bshf_pkg::ELAPSED_W-1:0] : trial[bshf_pkg::ELAPSED_W-1:0];
         low_in = {low_ff[bshf_pkg::CHAN_W-2:0], 1'b0};
         quo_in = {quo_ff[bshf_pkg::CHAN_W-2:0], ge};
      end

      if (cmd.store) begin
         case (cmd.ch)
            bshf_pkg::CH_RED:   color_in[23:16] = sat;
            bshf_pkg::CH_GREEN: color_in[15:8]  = sat;
            default:            color_in[7:0]   = sat;
         endcase
      end

      if (cmd.load_out) begin
         last_color_in  = color_ff;
         rsp_valid_in   = 1'b1;
         rsp_red_in     = color_ff[23:16];
         rsp_green_in   = color_ff[15:8];
         rsp_blue_in    = color_ff[7:0];
         rsp_changed_in = changed_ff;
         rsp_phase_in   = phase_ff;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         up_color_ff    <= '0;
         down_color_ff  <= '0;
         hold_time_ff   <= '0;
         sweep_time_ff  <= bshf_pkg::HOLD_W'(1);
         phase_ff       <= bshf_pkg::PH_START;
         sweep_start_ff <= '0;
         hold_start_ff  <= '0;
         last_color_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         up_color_ff    <= up_color_in;
         down_color_ff  <= down_color_in;
         hold_time_ff   <= hold_time_in;
         sweep_time_ff  <= sweep_time_in;
         phase_ff       <= phase_in;
         sweep_start_ff <= sweep_start_in;
         hold_start_ff  <= hold_start_in;
         last_color_ff  <= last_color_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      elapsed_ff     <= elapsed_in;
      up_ff          <= up_in;
      changed_ff     <= changed_in;
      color_ff       <= color_in;
      rem_ff         <= rem_in;
      low_ff         <= low_in;
      quo_ff         <= quo_in;
      rsp_red_ff     <= rsp_red_in;
      rsp_green_ff   <= rsp_green_in;
      rsp_blue_ff    <= rsp_blue_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_phase_ff   <= rsp_phase_in;
   end

   assign st.blend    = ev_blend;
   assign st.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_red     = rsp_red_ff;
   assign rsp_green   = rsp_green_ff;
   assign rsp_blue    = rsp_blue_ff;
   assign rsp_changed = rsp_changed_ff;
   assign rsp_phase   = rsp_phase_ff;

endmodule
